// ===== sv/winograd_filter_transform_defines.svh =====
// Assertion helpers shared by the transform RTL.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef WINOGRAD_FILTER_TRANSFORM_DEFINES_SVH
`define WINOGRAD_FILTER_TRANSFORM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WFT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define WFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wft_pkg.sv =====
package wft_pkg;

	// Field widths fixed by the interface.
	localparam int TAP_W   = 16;
	localparam int IDX_W   = 9;
	localparam int CNT_W   = 10;
	localparam int COEFF_W = 20;
	localparam int ADDR_W  = 22;

	// Internal widths: row-transform partial sums, the O*C plane size and c*O+o.
	localparam int TMP_W   = 18;
	localparam int PLANE_W = 2 * CNT_W;
	localparam int BASE_W  = 20;

	// Largest count honored in the range check and the address.
	localparam int MAX_DIM = 512;

	// One 4x4 transformed tile per filter.
	localparam int TILE_ELEMS = 16;
	localparam int POS_W      = $clog2(TILE_ELEMS);

	// Counts after reset.
	localparam int CNT_RESET = 256;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_OUTPUTS  = 1'b0,
		CFG_NUM_CHANNELS = 1'b1
	} cfg_reg_t;

	typedef logic signed [TAP_W-1:0]   tap_t;
	typedef logic signed [TMP_W-1:0]   tmp_t;
	typedef logic signed [COEFF_W-1:0] coeff_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [POS_W-1:0]          pos_t;

	// Counts above the supported dimension are treated as that dimension.
	function automatic cnt_t clamp_dim(cnt_t v);
		return (int'(v) > MAX_DIM) ? CNT_W'(MAX_DIM) : v;
	endfunction

endpackage

// ===== sv/wft_ifs.sv =====
// Filter channel: nine taps plus the filter and channel indices.
interface wft_filt_if;
	import wft_pkg::*;

	logic valid;
	logic ready;
	tap_t tap_0_0;
	tap_t tap_0_1;
	tap_t tap_0_2;
	tap_t tap_1_0;
	tap_t tap_1_1;
	tap_t tap_1_2;
	tap_t tap_2_0;
	tap_t tap_2_1;
	tap_t tap_2_2;
	idx_t filter_index;
	idx_t channel_index;

	modport source (
		output valid, tap_0_0, tap_0_1, tap_0_2, tap_1_0, tap_1_1, tap_1_2,
		       tap_2_0, tap_2_1, tap_2_2, filter_index, channel_index,
		input  ready
	);
	modport sink (
		input  valid, tap_0_0, tap_0_1, tap_0_2, tap_1_0, tap_1_1, tap_1_2,
		       tap_2_0, tap_2_1, tap_2_2, filter_index, channel_index,
		output ready
	);
endinterface

// Coefficient channel: one transformed coefficient and its store address.
interface wft_coef_if;
	import wft_pkg::*;

	logic   valid;
	logic   ready;
	coeff_t coeff_value;
	addr_t  store_address;
	logic [1:0] tile_row;
	logic [1:0] tile_col;
	logic   last_of_tile;
	logic   index_error;

	modport source (
		output valid, coeff_value, store_address, tile_row, tile_col,
		       last_of_tile, index_error,
		input  ready
	);
	modport sink (
		input  valid, coeff_value, store_address, tile_row, tile_col,
		       last_of_tile, index_error,
		output ready
	);
endinterface

// ===== sv/winograd_filter_transform.sv =====
// Winograd F(2x2,3x3) filter transform, U = G f G^T, exact in Q5.14.
// The filt channel takes one 3x3 filter (nine Q3.12 taps) with its output
// filter index o and input channel index c per transaction. The coef channel
// returns sixteen transactions per filter in row-major tile order, each with
// the coefficient, the store address (4*row+col)*O*C + c*O + o, the tile
// position and a last flag on the sixteenth. An index at or above its
// configured count raises index_error and forces the address to zero.
// Counts O and C are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, the block does not enforce it. Stages: input
// register, row transform, column transform, output serializer; the serializer
// sends one coefficient per transaction, one result per cycle while coef.ready
// is high, and loads the next tile as the last coefficient of a tile leaves;
// the three front stages keep accepting filters while the serializer is busy.
// When coef.ready is low, the serializer holds; the front stages fill up and
// filt.ready drops, nothing is lost or repeated.
// Reset clears all valid bits and sets both counts to 256.
`include "winograd_filter_transform_defines.svh"

module winograd_filter_transform (
	input  logic                             clk,
	input  logic                             arst_n,
	wft_filt_if.sink                         filt,
	wft_coef_if.source                       coef,
	input  logic                             cfg_we,
	input  logic [wft_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wft_pkg::CNT_W-1:0]        cfg_data
);
	import wft_pkg::*;

	localparam pos_t LAST_POS = POS_W'(TILE_ELEMS - 1);

	// Configuration registers and their clamped values.
	cnt_t num_outputs_q;
	cnt_t num_channels_q;
	cnt_t oc;
	cnt_t cc;

	// Stage 1: captured filter.
	logic v_s1;
	tap_t f_s1 [3][3];
	idx_t o_s1;
	idx_t c_s1;

	// Stage 2: row transform, plane size, range check.
	logic v_s2;
	tmp_t tmp_s2 [4][3];
	logic [PLANE_W-1:0] plane_s2;
	logic err_s2;
	idx_t o_s2;
	idx_t c_s2;

	// Stage 3: column transform, base address.
	logic v_s3;
	coeff_t u_s3 [TILE_ELEMS];
	logic [PLANE_W-1:0] plane_s3;
	logic [BASE_W-1:0] base_s3;
	logic err_s3;

	// Stage 4: output serializer.
	logic v_s4;
	coeff_t coeff_s4 [TILE_ELEMS];
	addr_t addr_s4;
	logic [PLANE_W-1:0] plane_s4;
	pos_t pos_s4;
	logic err_s4;

	// Handshake chain.
	logic rdy1, rdy2, rdy3;
	logic out_fire, ser_last, ser_free, load_s4;

	// Combinational stage results.
	tmp_t tmp_d [4][3];
	coeff_t u_d [TILE_ELEMS];
	logic err_d;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_outputs_q  <= CNT_W'(CNT_RESET);
			num_channels_q <= CNT_W'(CNT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_OUTPUTS:  num_outputs_q  <= cfg_data;
				CFG_NUM_CHANNELS: num_channels_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign oc = clamp_dim(num_outputs_q);
	assign cc = clamp_dim(num_channels_q);

	// Ready propagates back from the serializer; each stage moves when the next frees.
	assign out_fire = coef.valid && coef.ready;
	assign ser_last = v_s4 && (pos_s4 == LAST_POS);
	assign ser_free = !v_s4 || (coef.ready && ser_last);
	assign load_s4  = v_s3 && ser_free;
	assign rdy3     = !v_s3 || ser_free;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign filt.ready = rdy1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= filt.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (load_s4) begin
				v_s4 <= 1'b1;
			end else if (out_fire && ser_last) begin
				v_s4 <= 1'b0;
			end
		end
	end

	// Tile position counter of the serializer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s4 <= '0;
		end else if (load_s4) begin
			pos_s4 <= '0;
		end else if (out_fire) begin
			pos_s4 <= pos_s4 + POS_W'(1);
		end
	end

	// Row transform: tmp = 2G * f, weights counted in halves.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			tmp_d[0][j] = TMP_W'(f_s1[0][j]) <<< 1;
			tmp_d[1][j] = TMP_W'(f_s1[0][j]) + TMP_W'(f_s1[1][j]) + TMP_W'(f_s1[2][j]);
			tmp_d[2][j] = TMP_W'(f_s1[0][j]) - TMP_W'(f_s1[1][j]) + TMP_W'(f_s1[2][j]);
			tmp_d[3][j] = TMP_W'(f_s1[2][j]) <<< 1;
		end
	end

	assign err_d = ({1'b0, o_s1} >= oc) || ({1'b0, c_s1} >= cc);

	// Column transform: U = tmp * (2G)^T, laid out row-major.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			u_d[4*i]     = COEFF_W'(tmp_s2[i][0]) <<< 1;
			u_d[4*i + 1] = COEFF_W'(tmp_s2[i][0]) + COEFF_W'(tmp_s2[i][1])
			             + COEFF_W'(tmp_s2[i][2]);
			u_d[4*i + 2] = COEFF_W'(tmp_s2[i][0]) - COEFF_W'(tmp_s2[i][1])
			             + COEFF_W'(tmp_s2[i][2]);
			u_d[4*i + 3] = COEFF_W'(tmp_s2[i][2]) <<< 1;
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (rdy1 && filt.valid) begin
			f_s1[0][0] <= filt.tap_0_0;
			f_s1[0][1] <= filt.tap_0_1;
			f_s1[0][2] <= filt.tap_0_2;
			f_s1[1][0] <= filt.tap_1_0;
			f_s1[1][1] <= filt.tap_1_1;
			f_s1[1][2] <= filt.tap_1_2;
			f_s1[2][0] <= filt.tap_2_0;
			f_s1[2][1] <= filt.tap_2_1;
			f_s1[2][2] <= filt.tap_2_2;
			o_s1       <= filt.filter_index;
			c_s1       <= filt.channel_index;
		end
		if (rdy2 && v_s1) begin
			tmp_s2   <= tmp_d;
			plane_s2 <= PLANE_W'(oc) * PLANE_W'(cc);
			err_s2   <= err_d;
			o_s2     <= o_s1;
			c_s2     <= c_s1;
		end
		if (rdy3 && v_s2) begin
			u_s3     <= u_d;
			err_s3   <= err_s2;
			plane_s3 <= err_s2 ? '0 : plane_s2;
			base_s3  <= err_s2 ? '0 : BASE_W'(BASE_W'(c_s2) * BASE_W'(oc) + BASE_W'(o_s2));
		end
	end

	// Serializer: shift out one coefficient per transaction, step the address by O*C.
	always_ff @(posedge clk) begin
		if (load_s4) begin
			coeff_s4 <= u_s3;
			addr_s4  <= ADDR_W'(base_s3);
			plane_s4 <= plane_s3;
			err_s4   <= err_s3;
		end else if (out_fire) begin
			for (int k = 0; k < TILE_ELEMS - 1; k++) begin
				coeff_s4[k] <= coeff_s4[k+1];
			end
			addr_s4 <= addr_s4 + ADDR_W'(plane_s4);
		end
	end

	assign coef.valid         = v_s4;
	assign coef.coeff_value   = coeff_s4[0];
	assign coef.store_address = addr_s4;
	assign coef.tile_row      = pos_s4[3:2];
	assign coef.tile_col      = pos_s4[1:0];
	assign coef.last_of_tile  = (pos_s4 == LAST_POS);
	assign coef.index_error   = err_s4;

	// A new tile always starts at position zero.
	`WFT_ASSERT_NEXT(a_load_starts_tile, load_s4,
		coef.valid && coef.tile_row == 2'd0 && coef.tile_col == 2'd0,
		"tile did not start at position zero")
	// Within a tile, the position steps by one per transaction.
	`WFT_ASSERT_NEXT(a_pos_steps, out_fire && !coef.last_of_tile,
		coef.valid && {coef.tile_row, coef.tile_col}
			== $past({coef.tile_row, coef.tile_col}) + 4'd1,
		"tile position did not advance by one")
	// The serializer empties after the last result unless a new tile loads.
	`WFT_ASSERT_NEXT(a_drain_after_last, out_fire && coef.last_of_tile && !load_s4,
		!coef.valid, "serializer stayed valid after the last result")
	// Out-of-range indices never produce a nonzero address.
	`WFT_ASSERT_SAME(a_err_addr_zero, coef.valid && coef.index_error,
		coef.store_address == '0, "nonzero address with index error")

endmodule

// ===== tb/wft_checker.sv =====
// Watches both channels and the register port, predicts the sixteen transformed
// coefficients of every accepted filter and compares them in order.
module wft_checker import wft_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	wft_filt_if                  filt,
	wft_coef_if                  coef,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output int unsigned          mismatches,
	output int unsigned          pending,
	output int unsigned          checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct {
		coeff_t     value;
		addr_t      addr;
		logic [1:0] row;
		logic [1:0] col;
		logic       last;
		logic       err;
	} tile_coeff_t;

	// Shadow copies of the filter and channel counts.
	cnt_t outputs_cnt;
	cnt_t channels_cnt;

	tile_coeff_t expected_coeffs[$];
	tile_coeff_t head;
	int          filt_taps[3][3];

	// One row of the doubled G matrix applied to a column of three values, so
	// that every halving becomes a unit weight and the sum stays exact.
	function automatic int g2_mix(int unsigned k, int a0, int a1, int a2);
		case (k)
			0: return 2 * a0;
			1: return a0 + a1 + a2;
			2: return a0 - a1 + a2;
			default: return 2 * a2;
		endcase
	endfunction

	// Queue the whole 4x4 tile of one filter in row-major order.
	function automatic void predict_tile(int f[3][3], int unsigned o, int unsigned c);
		int          rowt[4][3];
		int unsigned oc;
		int unsigned cc;
		logic        bad;
		tile_coeff_t ent;
		oc  = (outputs_cnt > MAX_DIM) ? MAX_DIM : outputs_cnt;
		cc  = (channels_cnt > MAX_DIM) ? MAX_DIM : channels_cnt;
		bad = (o >= oc) || (c >= cc);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 3; j++)
				rowt[i][j] = g2_mix(i, f[0][j], f[1][j], f[2][j]);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				ent.value = coeff_t'(g2_mix(j, rowt[i][0], rowt[i][1], rowt[i][2]));
				ent.addr  = bad ? '0 : addr_t'((4 * i + j) * oc * cc + c * oc + o);
				ent.row   = 2'(i);
				ent.col   = 2'(j);
				ent.last  = (i == 3) && (j == 3);
				ent.err   = bad;
				expected_coeffs = {expected_coeffs, ent};
			end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outputs_cnt  <= cnt_t'(CNT_RESET);
			channels_cnt <= cnt_t'(CNT_RESET);
			expected_coeffs.delete();
			mismatches = 0;
			checked    = 0;
			pending   <= 0;
		end else begin
			// Register writes take effect for filters accepted from the next edge on.
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_OUTPUTS:  outputs_cnt  <= cfg_data;
					CFG_NUM_CHANNELS: channels_cnt <= cfg_data;
					default: ;
				endcase
			end

			// Compare each coefficient transaction with the oldest prediction.
			if (coef.valid === 1'b1 && coef.ready === 1'b1) begin
				checked++;
				if (expected_coeffs.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: unexpected coefficient value=%0d addr=%0d at %0t",
							coef.coeff_value, coef.store_address, $time);
				end else begin
					head = expected_coeffs.pop_front();
					if (coef.coeff_value !== head.value || coef.store_address !== head.addr ||
					    coef.tile_row !== head.row || coef.tile_col !== head.col ||
					    coef.last_of_tile !== head.last || coef.index_error !== head.err) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("mismatch at %0t: expected value=%0d addr=%0d pos=%0d,%0d last=%0b err=%0b",
								$time, head.value, head.addr, head.row, head.col, head.last, head.err);
							$display("                actual value=%0d addr=%0d pos=%0d,%0d last=%0b err=%0b",
								coef.coeff_value, coef.store_address, coef.tile_row, coef.tile_col,
								coef.last_of_tile, coef.index_error);
						end
					end
				end
			end

			// Every accepted filter transaction yields a full tile.
			if (filt.valid === 1'b1 && filt.ready === 1'b1) begin
				filt_taps[0][0] = int'(filt.tap_0_0);
				filt_taps[0][1] = int'(filt.tap_0_1);
				filt_taps[0][2] = int'(filt.tap_0_2);
				filt_taps[1][0] = int'(filt.tap_1_0);
				filt_taps[1][1] = int'(filt.tap_1_1);
				filt_taps[1][2] = int'(filt.tap_1_2);
				filt_taps[2][0] = int'(filt.tap_2_0);
				filt_taps[2][1] = int'(filt.tap_2_1);
				filt_taps[2][2] = int'(filt.tap_2_2);
				predict_tile(filt_taps, 32'(filt.filter_index), 32'(filt.channel_index));
			end

			pending <= expected_coeffs.size();
		end
	end

endmodule

// ===== tb/winograd_filter_transform_tb.sv =====
module winograd_filter_transform_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wft_pkg::*;

	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned PHASE_ITEMS    = 34;

	typedef struct {
		tap_t taps[9];
		idx_t filter_idx;
		idx_t channel_idx;
	} filter_item_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned checked;

	// Stimulus shaping, shared with the receiver process.
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_requests  = 0;
	int unsigned eff_outputs    = CNT_RESET;
	int unsigned eff_channels   = CNT_RESET;
	int unsigned filters_sent   = 0;
	int unsigned settings_used  = 0;
	int unsigned quiet_cycles   = 0;

	wft_filt_if filt_ch ();
	wft_coef_if coef_ch ();

	winograd_filter_transform u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.filt      (filt_ch),
		.coef      (coef_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wft_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.filt       (filt_ch),
		.coef       (coef_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	// 50 MHz clock.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		int unsigned hold_served;
		int unsigned hold_left;
		hold_served = 0;
		hold_left   = 0;
		coef_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				coef_ch.ready <= 1'b0;
			end else begin
				coef_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: too long without any transaction on either channel.
	always @(posedge clk) begin
		if ((filt_ch.valid === 1'b1 && filt_ch.ready === 1'b1) ||
		    (coef_ch.valid === 1'b1 && coef_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d coefficients outstanding",
				quiet_cycles, pending);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Taps alternate between two values in a checkerboard, which drives the
	// signed sums of the transform to their extremes.
	function automatic filter_item_t pattern_item(tap_t even_tap, tap_t odd_tap, idx_t o, idx_t c);
		filter_item_t it;
		for (int k = 0; k < 9; k++)
			it.taps[k] = ((k / 3 + k % 3) % 2 == 0) ? even_tap : odd_tap;
		it.filter_idx  = o;
		it.channel_idx = c;
		return it;
	endfunction

	// Random taps with extremes mixed in; indices mostly inside the counts.
	function automatic filter_item_t random_item();
		filter_item_t it;
		for (int k = 0; k < 9; k++)
			case ($urandom_range(7))
				0: it.taps[k] = 16'sh7FFF;
				1: it.taps[k] = 16'sh8000;
				default: it.taps[k] = tap_t'($urandom);
			endcase
		if ($urandom_range(99) < 85 && eff_outputs > 0 && eff_channels > 0) begin
			it.filter_idx  = idx_t'($urandom_range(eff_outputs - 1));
			it.channel_idx = idx_t'($urandom_range(eff_channels - 1));
		end else begin
			it.filter_idx  = idx_t'($urandom);
			it.channel_idx = idx_t'($urandom);
		end
		return it;
	endfunction

	function automatic cnt_t random_count();
		case ($urandom_range(6))
			0: return cnt_t'(1);
			1: return cnt_t'(MAX_DIM);
			2: return cnt_t'($urandom_range(1023, MAX_DIM + 1));
			3: return cnt_t'(0);
			default: return cnt_t'($urandom_range(MAX_DIM, 1));
		endcase
	endfunction

	// Offer one filter after a random idle gap and wait for its transaction.
	task automatic offer(filter_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			filt_ch.valid <= 1'b0;
			@(posedge clk);
		end
		filt_ch.tap_0_0       <= it.taps[0];
		filt_ch.tap_0_1       <= it.taps[1];
		filt_ch.tap_0_2       <= it.taps[2];
		filt_ch.tap_1_0       <= it.taps[3];
		filt_ch.tap_1_1       <= it.taps[4];
		filt_ch.tap_1_2       <= it.taps[5];
		filt_ch.tap_2_0       <= it.taps[6];
		filt_ch.tap_2_1       <= it.taps[7];
		filt_ch.tap_2_2       <= it.taps[8];
		filt_ch.filter_index  <= it.filter_idx;
		filt_ch.channel_index <= it.channel_idx;
		filt_ch.valid         <= 1'b1;
		@(posedge clk);
		while (filt_ch.ready !== 1'b1)
			@(posedge clk);
		filters_sent++;
	endtask

	// Stop offering and wait until every predicted coefficient has come back.
	task automatic wait_drained();
		filt_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Write both counts on back-to-back edges; only called while idle.
	task automatic set_counts(cnt_t o_cnt, cnt_t c_cnt);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NUM_OUTPUTS;
		cfg_data  <= o_cnt;
		@(posedge clk);
		cfg_index <= CFG_NUM_CHANNELS;
		cfg_data  <= c_cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		eff_outputs  = (o_cnt > MAX_DIM) ? MAX_DIM : o_cnt;
		eff_channels = (c_cnt > MAX_DIM) ? MAX_DIM : c_cnt;
		settings_used++;
	endtask

	initial begin
		filter_item_t item;
		int unsigned  idle_plan[4];
		int unsigned  stall_plan[4];
		idle_plan  = '{0, 88, 0, 35};
		stall_plan = '{0, 0, 88, 35};

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_NUM_OUTPUTS;
		cfg_data  = '0;
		filt_ch.valid = 1'b0;
		filt_ch.tap_0_0 = '0;
		filt_ch.tap_0_1 = '0;
		filt_ch.tap_0_2 = '0;
		filt_ch.tap_1_0 = '0;
		filt_ch.tap_1_1 = '0;
		filt_ch.tap_1_2 = '0;
		filt_ch.tap_2_0 = '0;
		filt_ch.tap_2_1 = '0;
		filt_ch.tap_2_2 = '0;
		filt_ch.filter_index  = '0;
		filt_ch.channel_index = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset counts of 256 each.
		offer(pattern_item(16'sh0000, 16'sh0000, 9'd0, 9'd0));
		offer(pattern_item(16'sh7FFF, 16'sh7FFF, 9'd255, 9'd255));
		offer(pattern_item(16'sh8000, 16'sh8000, 9'd511, 9'd0));
		offer(pattern_item(16'sh7FFF, 16'sh8000, 9'd0, 9'd256));
		offer(pattern_item(16'sh8000, 16'sh7FFF, 9'd17, 9'd200));
		item = pattern_item(16'sh0000, 16'sh0000, 9'd1, 9'd2);
		for (int k = 0; k < 9; k++)
			item.taps[k] = tap_t'((k % 2 == 1) ? -(k + 1) * 1000 : (k + 1) * 1000);
		offer(item);
		wait_drained();

		// Smallest counts: only index zero is in range.
		set_counts(cnt_t'(1), cnt_t'(1));
		item = random_item();
		item.filter_idx = 9'd0;
		item.channel_idx = 9'd0;
		offer(item);
		item = random_item();
		item.filter_idx = 9'd1;
		item.channel_idx = 9'd0;
		offer(item);
		item = random_item();
		item.filter_idx = 9'd0;
		item.channel_idx = 9'd1;
		offer(item);
		wait_drained();

		// Largest counts: the top indices reach the last store address.
		set_counts(cnt_t'(MAX_DIM), cnt_t'(MAX_DIM));
		offer(pattern_item(16'sh7FFF, 16'sh7FFF, 9'd511, 9'd511));
		offer(pattern_item(16'sh7FFF, 16'sh8000, 9'd0, 9'd0));
		wait_drained();

		// Counts above the supported dimension behave as the dimension itself.
		set_counts(cnt_t'(1023), cnt_t'(600));
		offer(pattern_item(16'sh8000, 16'sh7FFF, 9'd511, 9'd511));
		offer(pattern_item(16'sh1234, 16'shEDCB, 9'd300, 9'd511));
		wait_drained();

		// A count of zero puts every index out of range.
		set_counts(cnt_t'(0), cnt_t'(5));
		offer(pattern_item(16'sh4000, 16'shC000, 9'd0, 9'd0));
		wait_drained();
		set_counts(cnt_t'(7), cnt_t'(0));
		offer(pattern_item(16'shC000, 16'sh4000, 9'd3, 9'd0));
		wait_drained();

		// Random phases, each with its own counts and idling profile.
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 0)
				set_counts(cnt_t'($urandom_range(MAX_DIM, 1)), cnt_t'($urandom_range(MAX_DIM, 1)));
			else
				set_counts(random_count(), random_count());
			send_idle_pct  = idle_plan[ph];
			recv_stall_pct = stall_plan[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Back-pressure burst while the sender keeps offering.
				if (ph == 0 && n == 5)
					hold_requests++;
				if ($urandom_range(19) == 0)
					wait_drained();
				offer(random_item());
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d filters sent, %0d coefficients checked under %0d count settings",
			filters_sent, checked, settings_used);
		$display("summary: %0d mismatches, %0d coefficients still outstanding", mismatches, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wft_pkg.sv
sv/wft_ifs.sv
sv/winograd_filter_transform.sv
tb/wft_checker.sv
tb/winograd_filter_transform_tb.sv
